>>> src/bswc_pkg.sv
`timescale 1ns / 1ps
package bswc_pkg;

   // fixed field widths
   localparam int LIMIT_W      = 42;
   localparam int TOTAL_W      = 48;
   localparam int VALUE_PORT_W = 32;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 4;

   // register index of sum_limit (paddr[3])
   localparam logic REG_SUM_LIMIT = 1'b0;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CHECK = 3'b010,
      S_DONE  = 3'b100
   } state_type;

endpackage

>>> src/bounded_sum_window_counter.sv
`timescale 1ns / 1ps
// an item is taken in IDLE and settled in CHECK, after CHECK has dropped every window entry
// that must go; each drop is one read of the window ram through its single read port
// no new item is taken until the last one is settled, and every entry is written once and
// dropped at most once
// an item marked last then goes to DONE and waits until the result register is free
// reset: synchronous, clears pointers, sums, flags and sum_limit; the window ram is not cleared
module bounded_sum_window_counter
   import bswc_pkg::*;
#(
   parameter int WINDOW_DEPTH = 1024,
   parameter int VALUE_BITS   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   // input items
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [VALUE_PORT_W-1:0] req_tdata,   // [31:0] value
   input  logic                    req_tlast,   // last
   // result items
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [TOTAL_W-1:0]      rsp_tdata,   // [47:0] run_count
   output logic                    rsp_tuser,   // [0] window_overflow
   // configuration
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int VW    = (VALUE_BITS < VALUE_PORT_W) ? VALUE_BITS : VALUE_PORT_W;
   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(WINDOW_DEPTH);

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0] limit_ff;
   logic [VW-1:0]      value_ff, value_in;
   logic               last_ff, last_in;
   logic [PTR_W-1:0]   oldest_ff, oldest_in;
   logic [PTR_W-1:0]   newest_ff, newest_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [TOTAL_W-1:0] sum_ff, sum_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               mem_wr_en;
   logic [VW-1:0]      mem_rd_data;
   logic [TOTAL_W:0]   sum_plus_v;
   logic [TOTAL_W:0]   total_plus_len;
   logic               need_drop;
   logic               too_big;
   logic               evict;
   logic               rsp_free;
   logic               csr_write;

   // window store
   bswc_ram #(
      .DATA_W (VW),
      .DEPTH  (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (newest_ff),
      .wr_data (value_ff),
      .rd_addr (oldest_in),
      .rd_data (mem_rd_data)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_SUM_LIMIT) ? CSR_DATA_W'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_write && csr_paddr[3] == REG_SUM_LIMIT) begin
         limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   // window tests
   assign sum_plus_v     = {1'b0, sum_ff} + (TOTAL_W + 1)'(value_ff);
   assign need_drop      = (len_ff != '0) && (sum_plus_v > (TOTAL_W + 1)'(limit_ff));
   assign too_big        = (TOTAL_W + 1)'(value_ff) > (TOTAL_W + 1)'(limit_ff);
   assign evict          = (len_ff == LEN_FULL);
   assign total_plus_len = {1'b0, total_ff} + (TOTAL_W + 1)'(len_in);
   assign rsp_free       = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_wr_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               value_in = req_tdata[VW-1:0];
               last_in  = req_tlast;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (need_drop) begin
               // drop the oldest entry, its value is on the ram output
               sum_in    = sum_ff - TOTAL_W'(mem_rd_data);
               oldest_in = (oldest_ff == PTR_LAST) ? '0 : oldest_ff + 1'b1;
               len_in    = len_ff - 1'b1;
            end else begin
               if (too_big) begin
                  sum_in = '0;
               end else begin
                  // append, evicting the oldest entry when the store is full
                  mem_wr_en = 1'b1;
                  newest_in = (newest_ff == PTR_LAST) ? '0 : newest_ff + 1'b1;
                  if (evict) begin
                     ovf_in    = 1'b1;
                     oldest_in = (oldest_ff == PTR_LAST) ? '0 : oldest_ff + 1'b1;
                     sum_in    = sum_ff - TOTAL_W'(mem_rd_data) + TOTAL_W'(value_ff);
                  end else begin
                     len_in = len_ff + 1'b1;
                     sum_in = sum_ff + TOTAL_W'(value_ff);
                  end
               end
               // saturating total of runs
               total_in = total_plus_len[TOTAL_W] ? '1 : total_plus_len[TOTAL_W-1:0];
               state_in = last_ff ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = total_ff;
               rsp_ovf_in   = ovf_ff;
               oldest_in    = '0;
               newest_in    = '0;
               len_in       = '0;
               sum_in       = '0;
               total_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         len_ff       <= '0;
         sum_ff       <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item payload and result registers
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // window length stays within the store
   assert property (@(posedge clock) disable iff (reset) len_ff <= LEN_FULL)
      else $error("window length above depth");

   // an empty window has both pointers together
   assert property (@(posedge clock) disable iff (reset)
      (len_ff == '0) |-> (oldest_ff == newest_ff))
      else $error("empty window with split pointers");

   // a finished sequence leaves a result and a cleared window
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=>
         (rsp_valid_ff && len_ff == '0 && total_ff == '0 && !ovf_ff && state_ff == S_IDLE))
      else $error("sequence end did not clear state");

endmodule

>>> src/bswc_ram.sv
`timescale 1ns / 1ps
module bswc_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
